// File: design/ranked_top_k_list_insert_top_defines.svh
// Assertion macros for the ranked top-K list RTL.
`ifndef RANKED_TOP_K_LIST_INSERT_TOP_DEFINES_SVH
`define RANKED_TOP_K_LIST_INSERT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define RTKL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define RTKL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rtkl_pkg.sv
// Shared types and constants of the ranked top-K list.
`timescale 1ns / 1ps

package rtkl_pkg;

    // Slots held in the list, and ranks reported per input word.
    localparam int LIST_DEPTH = 16;
    localparam int REPORT_MAX = 16;
    localparam int RPT_N      = (LIST_DEPTH < REPORT_MAX) ? LIST_DEPTH : REPORT_MAX;

    localparam int IDX_W  = $clog2(LIST_DEPTH);
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int RANK_W = 4;

    localparam int ID_W    = 64;
    localparam int SCORE_W = 32;
    localparam int DCNT_W  = 16;
    localparam int KIND_W  = 8;

    localparam int IN_W  = 184;
    localparam int OUT_W = 200;

    // One list entry.
    typedef struct packed {
        logic        [KIND_W-1:0]  kind;
        logic        [DCNT_W-1:0]  dcount;
        logic signed [SCORE_W-1:0] score;
        logic        [ID_W-1:0]    name;
        logic        [ID_W-1:0]    account;
    } slot_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic insert;
        logic emit;
    } ctl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic list_empty;
        logic scan_last;
        logic emit_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: design/rtkl_ctrl.sv
// Sequencing state machine of the ranked top-K list.
`timescale 1ns / 1ps

module rtkl_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  rtkl_pkg::dp_status_t  status,
    output rtkl_pkg::ctl_cmd_t    cmd
);
    import rtkl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_REPORT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Pick the next phase.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = status.list_empty ? ST_INSERT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (status.out_free && status.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decode commands from the state.
    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.insert = (state_reg == ST_INSERT);
    assign cmd.emit   = (state_reg == ST_REPORT) && status.out_free;

endmodule

// File: design/rtkl_datapath.sv
// Slot storage, match scan, insertion and result register of the ranked list.
`timescale 1ns / 1ps
`include "ranked_top_k_list_insert_top_defines.svh"

module rtkl_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rtkl_pkg::ctl_cmd_t           cmd,
    output rtkl_pkg::dp_status_t         status,
    // account_id[63:0], name_id[127:64], entry_score[159:128],
    // defend_count[175:160], entry_kind[183:176]
    input  logic [rtkl_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // rank[3:0], out_account[67:4], out_name[131:68], out_score[163:132],
    // out_count[179:164], out_kind[187:180], accepted[188],
    // placed_rank[192:189], zero[199:193]
    output logic [rtkl_pkg::OUT_W-1:0]   m_tdata,
    output logic                         m_tlast
);
    import rtkl_pkg::*;

    slot_t             slot_reg [LIST_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    slot_t             in_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  wr_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic              pos_found_reg;
    logic              ok_reg;
    logic [RANK_W-1:0] placed_reg;

    slot_t             out_slot_reg;
    logic [RANK_W-1:0] out_rank_reg;
    logic              out_ok_reg;
    logic [RANK_W-1:0] out_placed_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    slot_t             rd_slot;
    slot_t             in_word;
    logic              keep;
    logic [CNT_W-1:0]  idx_ext;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  ins_pos;
    logic              ins_ok;
    logic [CNT_W-1:0]  rpt_n;
    logic              out_free;

    // Unpack the input word.
    assign in_word.account = s_tdata[63:0];
    assign in_word.name    = s_tdata[127:64];
    assign in_word.score   = s_tdata[159:128];
    assign in_word.dcount  = s_tdata[175:160];
    assign in_word.kind    = s_tdata[183:176];

    // Single read port, shared by scan and report.
    assign rd_slot = slot_reg[idx_reg];
    assign keep    = !((rd_slot.account == in_reg.account) && (rd_slot.name == in_reg.name));
    assign idx_ext = CNT_W'(idx_reg);
    assign idx_inc = idx_ext + CNT_W'(1);

    // Insertion point after the survivors are closed up.
    assign ins_pos = pos_found_reg ? pos_reg : wr_reg;
    assign ins_ok  = pos_found_reg || (wr_reg != CNT_W'(LIST_DEPTH));

    assign rpt_n    = (count_reg > CNT_W'(RPT_N)) ? CNT_W'(RPT_N) : count_reg;
    assign out_free = !out_valid_reg || m_tready;

    assign status.list_empty = (count_reg == '0);
    assign status.scan_last  = (idx_inc == count_reg);
    assign status.emit_last  = (idx_inc == rpt_n);
    assign status.out_free   = out_free;

    // Compact survivors in place, then shift down and drop in the new entry.
    always_ff @(posedge aclk) begin
        if (cmd.insert && ins_ok) begin
            if (ins_pos == '0) begin
                slot_reg[0] <= in_reg;
            end
            for (int j = 1; j < LIST_DEPTH; j++) begin
                if (CNT_W'(j) == ins_pos) begin
                    slot_reg[j] <= in_reg;
                end else if (CNT_W'(j) > ins_pos) begin
                    slot_reg[j] <= slot_reg[j-1];
                end
            end
        end else if (cmd.scan && keep) begin
            slot_reg[wr_reg[IDX_W-1:0]] <= rd_slot;
        end
    end

    // Capture the input word.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= in_word;
        end
    end

    // Scan pointers, fill count and insert outcome.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            idx_reg       <= '0;
            wr_reg        <= '0;
            pos_reg       <= '0;
            pos_found_reg <= 1'b0;
            ok_reg        <= 1'b0;
            placed_reg    <= '0;
        end else begin
            if (cmd.load) begin
                idx_reg       <= '0;
                wr_reg        <= '0;
                pos_found_reg <= 1'b0;
            end else if (cmd.scan) begin
                idx_reg <= idx_reg + 1'b1;
                if (keep) begin
                    wr_reg <= wr_reg + CNT_W'(1);
                    if (!pos_found_reg && (in_reg.score >= rd_slot.score)) begin
                        pos_reg       <= wr_reg;
                        pos_found_reg <= 1'b1;
                    end
                end
            end else if (cmd.insert) begin
                idx_reg <= '0;
                ok_reg  <= ins_ok;
                if (ins_ok) begin
                    placed_reg <= RANK_W'(ins_pos);
                    count_reg  <= (wr_reg == CNT_W'(LIST_DEPTH)) ? wr_reg
                                                                 : wr_reg + CNT_W'(1);
                end else begin
                    placed_reg <= '0;
                    count_reg  <= wr_reg;
                end
            end else if (cmd.emit) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Result register: load on emit, drop when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_slot_reg   <= rd_slot;
            out_rank_reg   <= RANK_W'(idx_reg);
            out_ok_reg     <= ok_reg;
            out_placed_reg <= placed_reg;
            out_last_reg   <= status.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0, out_placed_reg, out_ok_reg, out_slot_reg.kind,
                       out_slot_reg.dcount, out_slot_reg.score, out_slot_reg.name,
                       out_slot_reg.account, out_rank_reg};

    `RTKL_ASSERT_IMP(a_scan_in_range, aclk, aresetn, cmd.scan, idx_ext < count_reg, "scan index past occupied slots")
    `RTKL_ASSERT_IMP(a_write_behind_read, aclk, aresetn, cmd.scan, wr_reg <= idx_ext, "compaction write ahead of read")
    `RTKL_ASSERT_IMP(a_emit_into_free, aclk, aresetn, cmd.emit, out_free, "result overwritten before taken")
    `RTKL_ASSERT_NXT(a_list_nonempty, aclk, aresetn, cmd.insert, count_reg != '0, "list empty after insert")

endmodule

// File: design/ranked_top_k_list_insert_top.sv
// Top level of the ranked top-K list: controller and datapath.
`timescale 1ns / 1ps

// Keeps up to LIST_DEPTH (16) entries ranked by descending score. Each input
// word removes every entry with the same account and name, closes up the
// list, inserts the new entry above any equal score (rejected when the list
// is full of higher scores), then streams the occupied entries in rank
// order with tlast on the final one; every result word carries whether the
// input was placed and the rank it took. The match scan reads the entries
// held before the word one per cycle through the single read port of the
// slot array, and the report reads the results one per cycle through the
// same port while the output register is free to take them. A new word is
// taken once the last result has been loaded into the output register,
// even if that result is still waiting to be taken.
module ranked_top_k_list_insert_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // account_id[63:0], name_id[127:64], entry_score[159:128],
    // defend_count[175:160], entry_kind[183:176]
    input  logic [rtkl_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // rank[3:0], out_account[67:4], out_name[131:68], out_score[163:132],
    // out_count[179:164], out_kind[187:180], accepted[188],
    // placed_rank[192:189], zero[199:193]
    output logic [rtkl_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tlast
);
    import rtkl_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    // Sequence the phases.
    rtkl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the list and build the result words.
    rtkl_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
